// ===== sv/txr_pkg.sv =====
// Shared types and constants for the transmit ring with overrun marker.
// Used by the store, the controller, the top level and the checker.
// Has no dependencies.
`default_nettype none

package txr_pkg;

    // The ring is 2048 bytes, which matches the 11-bit position fields.
    localparam int C_DEPTH      = 2048;
    localparam int C_POS_W      = $clog2(C_DEPTH);
    localparam int C_BANK_DEPTH = C_DEPTH / 2;
    localparam int C_BANK_AW    = $clog2(C_BANK_DEPTH);
    localparam logic [7:0] C_MARKER = 8'h5E;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_DONE  = 2'd1,
        CMD_FETCH = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         char_in;
        logic [C_POS_W-1:0] fetch_index;
    } t_in;

    typedef struct packed {
        logic               byte_stored;
        logic               marker_stored;
        logic               overrun_pending;
        logic               chunk_issue;
        logic [C_POS_W-1:0] chunk_start;
        logic [C_POS_W-1:0] chunk_length;
        logic               transfer_busy;
        logic [7:0]         fetch_data;
    } t_out;

    // One write port of one bank of the byte store.
    typedef struct packed {
        logic                 we;
        logic [C_BANK_AW-1:0] addr;
        logic [7:0]           data;
    } t_bank_wr;

endpackage

`default_nettype wire

// ===== sv/tx_ring_with_overrun_marker_dma_top.sv =====
// Top level of the transmit ring with overrun marker and chunked transfer.
// Instantiates txr_ctrl and txr_store; depends on txr_pkg.
//
//   Channel  Direction  Handshake                Beat type
//   in       into block i_in_valid / o_in_stall   t_in  (command, char, index)
//   out      from block o_out_valid / i_out_stall t_out (status, chunk, fetch)
//
// The result beat appears in the cycle after the input beat is accepted,
// and a new beat can be accepted every cycle unless a stalled beat is held.
// That pace is set by the pointer update path in txr_ctrl and by
// the two byte-store banks, which take the marker and the byte together.
// Reset is synchronous and active low; it clears the pointers, the busy and
// overrun flags and the output valid. The byte store is not cleared.
// A stalled output holds its beat, and the input stalls only while that
// beat is held.
`default_nettype none

module tx_ring_with_overrun_marker_dma_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire txr_pkg::t_in  i_in_beat,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output txr_pkg::t_out      o_out_beat
);
    import txr_pkg::*;

    logic       w_accept;
    t_bank_wr   w_wr [2];
    t_out       w_res;
    logic       w_is_fetch;
    logic [7:0] w_rd_data;
    logic       r_out_valid;

    // The output register is free when it is empty or is being emptied now.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    txr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_beat     (i_in_beat),
        .o_wr       (w_wr),
        .o_res      (w_res),
        .o_is_fetch (w_is_fetch)
    );

    // The fetch is read at accept time; its data register only moves on a
    // fetch, so it still holds the right byte while the result is stalled.
    txr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_accept && (i_in_beat.command == CMD_FETCH)),
        .i_rd_pos  (i_in_beat.fetch_index),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Fetch data is reported only for a fetch and reads as zero otherwise.
    always_comb begin
        o_out_beat            = w_res;
        o_out_beat.fetch_data = w_is_fetch ? w_rd_data : 8'h00;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/txr_store.sv =====
// Byte store of the ring, split into an even and an odd bank so that a marker
// and a byte at neighboring positions can be written in the same cycle.
// Depends on txr_pkg.
`default_nettype none

module txr_store (
    input  wire logic                      i_clk,
    input  wire txr_pkg::t_bank_wr         i_wr [2],
    input  wire logic                      i_rd_en,
    input  wire logic [txr_pkg::C_POS_W-1:0] i_rd_pos,
    output logic [7:0]                     o_rd_data
);
    import txr_pkg::*;

    logic [7:0] r_rd [2];
    logic       r_sel;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic [7:0] r_mem [C_BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_wr[b].we) begin
                r_mem[i_wr[b].addr] <= i_wr[b].data;
            end
            if (i_rd_en) begin
                r_rd[b] <= r_mem[i_rd_pos[C_POS_W-1:1]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sel <= i_rd_pos[0];
        end
    end

    assign o_rd_data = r_rd[r_sel];

endmodule

`default_nettype wire

// ===== sv/txr_ctrl.sv =====
// Ring pointers, overrun mark and chunk issue logic with the result register.
// Produces the bank writes for the byte store. Depends on txr_pkg.
`default_nettype none

module txr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire txr_pkg::t_in  i_beat,
    output txr_pkg::t_bank_wr  o_wr [2],
    output txr_pkg::t_out      o_res,
    output logic               o_is_fetch
);
    import txr_pkg::*;

    typedef struct packed {
        logic               issue;
        logic               busy;
        logic [C_POS_W-1:0] start;
        logic [C_POS_W-1:0] len;
        logic [C_POS_W-1:0] end_pos;
    } t_chunk;

    // A chunk runs from the read position up to the write position, or to the
    // end of the ring when the stored data wraps.
    function automatic t_chunk f_chunk(input logic [C_POS_W-1:0] rp,
                                       input logic [C_POS_W-1:0] wp);
        t_chunk c;
        c = '0;
        if (wp != rp) begin
            c.issue = 1'b1;
            c.busy  = 1'b1;
            c.start = rp;
            if (rp < wp) begin
                c.len     = wp - rp;
                c.end_pos = wp;
            end else begin
                c.len     = C_POS_W'(0) - rp;
                c.end_pos = '0;
            end
        end
        return c;
    endfunction

    logic [C_POS_W-1:0] r_rp, r_wp, r_end;
    logic               r_busy, r_ovr;
    logic [C_POS_W-1:0] n_rp, n_wp, n_end;
    logic               n_busy, n_ovr;
    t_out               r_res, n_res;
    logic               r_fetch, n_fetch;

    logic [C_POS_W-1:0] w_wp_a, w_wp1, w_wp_b;
    logic               w_mark_ok, w_go_on, w_byte_ok;
    t_chunk             w_chunk;

    always_comb begin
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_end     = r_end;
        n_busy    = r_busy;
        n_ovr     = r_ovr;
        n_res     = '0;
        n_fetch   = 1'b0;
        w_wp_a    = r_wp + C_POS_W'(1);
        w_mark_ok = 1'b0;
        w_go_on   = 1'b0;
        w_wp1     = r_wp;
        w_wp_b    = r_wp;
        w_byte_ok = 1'b0;
        w_chunk   = '0;
        o_wr[0]   = '0;
        o_wr[1]   = '0;

        case (i_beat.command)
            CMD_PUT: begin
                // A pending overrun first tries to leave a marker in the ring.
                w_mark_ok = r_ovr && (w_wp_a != r_rp);
                w_go_on   = !r_ovr || w_mark_ok;
                w_wp1     = w_mark_ok ? w_wp_a : r_wp;
                w_wp_b    = w_wp1 + C_POS_W'(1);
                w_byte_ok = w_go_on && (w_wp_b != r_rp);
                n_wp      = w_byte_ok ? w_wp_b : w_wp1;
                if (w_go_on) begin
                    n_ovr = !w_byte_ok;
                end
                // Marker and byte sit at neighboring positions, so they
                // always land in different banks.
                if (w_byte_ok) begin
                    o_wr[w_wp1[0]].we   = i_accept;
                    o_wr[w_wp1[0]].addr = w_wp1[C_POS_W-1:1];
                    o_wr[w_wp1[0]].data = i_beat.char_in;
                end
                if (w_mark_ok) begin
                    o_wr[r_wp[0]].we   = i_accept;
                    o_wr[r_wp[0]].addr = r_wp[C_POS_W-1:1];
                    o_wr[r_wp[0]].data = C_MARKER;
                end
                if (!r_busy) begin
                    w_chunk = f_chunk(r_rp, n_wp);
                    n_busy  = w_chunk.busy;
                    if (w_chunk.issue) begin
                        n_end = w_chunk.end_pos;
                    end
                end
                n_res.byte_stored   = w_byte_ok;
                n_res.marker_stored = w_mark_ok;
            end
            CMD_DONE: begin
                // A completion while idle is spurious and changes nothing.
                if (r_busy) begin
                    n_rp    = r_end;
                    w_chunk = f_chunk(r_end, r_wp);
                    n_busy  = w_chunk.busy;
                    if (w_chunk.issue) begin
                        n_end = w_chunk.end_pos;
                    end
                end
            end
            CMD_FETCH: begin
                n_fetch = 1'b1;
            end
            default: begin
            end
        endcase

        n_res.overrun_pending = n_ovr;
        n_res.chunk_issue     = w_chunk.issue;
        n_res.chunk_start     = w_chunk.start;
        n_res.chunk_length    = w_chunk.len;
        n_res.transfer_busy   = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_end   <= '0;
            r_busy  <= 1'b0;
            r_ovr   <= 1'b0;
            r_fetch <= 1'b0;
        end else if (i_accept) begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_end   <= n_end;
            r_busy  <= n_busy;
            r_ovr   <= n_ovr;
            r_fetch <= n_fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res      = r_res;
    assign o_is_fetch = r_fetch;

endmodule

`default_nettype wire

// ===== sv/txr_checker.sv =====
// Port-level checks for the transmit ring top level, attached by bind.
// Depends on txr_pkg and tx_ring_with_overrun_marker_dma_top.
`default_nettype none

module txr_port_checks (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire txr_pkg::t_in  i_in_beat,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire txr_pkg::t_out o_out_beat
);
    import txr_pkg::*;

    // Every accepted beat gives a result beat in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted beat produced no result beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result beat changed");

    // An issued chunk starts the engine and never has zero length.
    a_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.chunk_issue) |->
            (o_out_beat.transfer_busy && (o_out_beat.chunk_length != '0)))
        else $error("chunk issued with idle engine or zero length");

    // A stored byte clears the overrun mark.
    a_byte_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.byte_stored) |-> !o_out_beat.overrun_pending)
        else $error("overrun still pending after a byte was stored");

    // A marker without its byte means the ring filled up again.
    a_marker_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.marker_stored && !o_out_beat.byte_stored) |->
            o_out_beat.overrun_pending)
        else $error("marker stored alone without overrun pending");

endmodule

bind tx_ring_with_overrun_marker_dma_top txr_port_checks u_txr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
